>>> rtl/function_timing_stats_table_top_defines.svh
// assertion macros for the function timing stats table
// used by function_timing_stats_table_top; expects clk and rst_n in scope
`ifndef FUNCTION_TIMING_STATS_TABLE_TOP_DEFINES_SVH
`define FUNCTION_TIMING_STATS_TABLE_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FTS_ASSERT_IMM(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define FTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fts_pkg.sv
// shared types, constants and helpers for the function timing stats table
// no dependencies; used by all rtl modules of the block except fts_ram
`timescale 1ns / 1ps

package fts_pkg;

  localparam int NUM_FUNCS_DEF = 256;
  localparam int TS_W          = 64;
  localparam int CNT_W         = 32;
  localparam int FI_W          = 8;
  localparam int IDX_EXT_W     = 16;
  localparam int IN_DATA_W     = 72;
  localparam int OUT_DATA_W    = 328;
  localparam int PAIR_SHIFT    = 1;   // divide by two call events per pair

  localparam logic [CNT_W-1:0] SAMPLE_LIMIT_RST = 32'd1000;

  typedef enum logic {
    EV_ENTRY = 1'b0,
    EV_EXIT  = 1'b1
  } ev_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DONE
  } state_t;

  // one table row per function
  typedef struct packed {
    logic [CNT_W-1:0] deact_cnt;
    logic [CNT_W-1:0] call_cnt;
    logic [TS_W-1:0]  sum_time;
    logic [TS_W-1:0]  max_dur;
    logic [TS_W-1:0]  min_dur;
    logic [TS_W-1:0]  start_time;
  } row_t;

  typedef struct packed {
    logic clear_step;
    logic load_in;
    logic latch_row;
    logic calc;
    logic commit;
  } fts_cmd_t;

  typedef struct packed {
    logic clear_last;
  } fts_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
    sat_inc32 = (v == '1) ? v : v + 32'd1;
  endfunction

endpackage

>>> rtl/fts_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module fts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/fts_ctrl.sv
// controller state machine: table clear after reset, then read, calc, commit per event
// depends on fts_pkg
`timescale 1ns / 1ps

module fts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  fts_pkg::fts_stat_t stat,
  output fts_pkg::fts_cmd_t  cmd
);

  fts_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fts_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      fts_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = fts_pkg::ST_IDLE;
        end
      end
      fts_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = fts_pkg::ST_READ;
        end
      end
      fts_pkg::ST_READ: begin
        cmd.latch_row = 1'b1;
        state_nxt     = fts_pkg::ST_CALC;
      end
      fts_pkg::ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = fts_pkg::ST_DONE;
      end
      fts_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = fts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fts_pkg::ST_CLEAR;
      end
    endcase
    out_valid_nxt = cmd.commit | (out_valid_r & ~out_tready);
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> rtl/fts_datapath.sv
// datapath: stats table ram, elapsed time, min/max/sum update, global counters
// depends on fts_pkg and fts_ram
`timescale 1ns / 1ps

module fts_datapath #(
  parameter int NUM_FUNCS = fts_pkg::NUM_FUNCS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fts_pkg::fts_cmd_t                  cmd,
  output fts_pkg::fts_stat_t                 stat,
  input  logic                               in_cmd,
  input  logic [fts_pkg::FI_W-1:0]           in_func,
  input  logic [fts_pkg::TS_W-1:0]           in_ts,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fts_pkg::CNT_W-1:0]          cfg_data,
  output logic [fts_pkg::OUT_DATA_W-1:0]     out_data
);

  localparam int ADDR_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
  localparam int ROW_W  = $bits(fts_pkg::row_t);

  logic [ADDR_W-1:0]                clr_addr_r;
  logic [fts_pkg::CNT_W-1:0]        sample_limit_r;
  logic [fts_pkg::TS_W-1:0]         event_total_r;
  logic [fts_pkg::CNT_W-1:0]        deact_total_r;

  fts_pkg::ev_kind_t                kind_r;
  logic [ADDR_W-1:0]                addr_r;
  logic [fts_pkg::TS_W-1:0]         ts_r;
  logic                             hit_r;
  fts_pkg::row_t                    row_r;
  logic [fts_pkg::TS_W-1:0]         el_r;
  fts_pkg::row_t                    new_row_r, new_row_nxt;
  logic                             req_r, req_nxt;
  logic [fts_pkg::TS_W-1:0]         evt_new_r, evt_new_nxt;
  logic [fts_pkg::OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  logic [fts_pkg::IDX_EXT_W-1:0]    idx_ext;
  logic [ADDR_W-1:0]                addr_in;
  logic                             hit_in;
  fts_pkg::row_t                    rd_row;
  logic [ROW_W-1:0]                 rd_data;
  logic                             wr_en;
  logic [ADDR_W-1:0]                wr_addr;
  logic [ROW_W-1:0]                 wr_data;

  assign idx_ext = {{(fts_pkg::IDX_EXT_W - fts_pkg::FI_W){1'b0}}, in_func};
  assign addr_in = idx_ext[ADDR_W-1:0];
  assign hit_in  = ({1'b0, idx_ext} < 17'(NUM_FUNCS));

  assign wr_en   = cmd.clear_step | (cmd.commit & hit_r);
  assign wr_addr = cmd.clear_step ? clr_addr_r : addr_r;
  assign wr_data = cmd.clear_step ? '0 : ROW_W'(new_row_r);

  fts_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_FUNCS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.load_in),
    .rd_addr (addr_in),
    .rd_data (rd_data)
  );

  assign rd_row          = fts_pkg::row_t'(rd_data);
  assign stat.clear_last = (clr_addr_r == ADDR_W'(NUM_FUNCS - 1));
  assign cfg_ready       = 1'b1;

  // control and global state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r     <= '0;
      sample_limit_r <= fts_pkg::SAMPLE_LIMIT_RST;
      event_total_r  <= '0;
      deact_total_r  <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (cfg_valid) begin
        sample_limit_r <= cfg_data;
      end
      if (cmd.commit) begin
        event_total_r <= evt_new_r;
        if (req_r) begin
          deact_total_r <= fts_pkg::sat_inc32(deact_total_r);
        end
      end
    end
  end

  // update of the selected row
  always_comb begin
    evt_new_nxt = event_total_r;
    if (hit_r && (event_total_r != '1)) begin
      evt_new_nxt = event_total_r + 64'd1;
    end
    req_nxt = hit_r && (kind_r == fts_pkg::EV_EXIT) &&
              ((evt_new_nxt >> fts_pkg::PAIR_SHIFT) >= 64'(sample_limit_r));

    new_row_nxt = row_r;
    if (kind_r == fts_pkg::EV_ENTRY) begin
      new_row_nxt.start_time = ts_r;
    end else begin
      new_row_nxt.call_cnt = fts_pkg::sat_inc32(row_r.call_cnt);
      // zero minimum means unset
      if ((el_r < row_r.min_dur) || (row_r.min_dur == '0)) begin
        new_row_nxt.min_dur = el_r;
      end
      if (el_r > row_r.max_dur) begin
        new_row_nxt.max_dur = el_r;
      end
      new_row_nxt.sum_time = row_r.sum_time + el_r;
      if (req_nxt) begin
        new_row_nxt.deact_cnt = fts_pkg::sat_inc32(row_r.deact_cnt);
      end
    end
  end

  always_comb begin
    out_data_nxt = '0;
    if (hit_r) begin
      out_data_nxt = {7'd0, new_row_r.deact_cnt, req_r, new_row_r.call_cnt,
                      new_row_r.sum_time, new_row_r.max_dur, new_row_r.min_dur, el_r};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= fts_pkg::ev_kind_t'(in_cmd);
      addr_r <= addr_in;
      ts_r   <= in_ts;
      hit_r  <= hit_in;
    end
    if (cmd.latch_row) begin
      row_r <= rd_row;
      el_r  <= (hit_r && (kind_r == fts_pkg::EV_EXIT)) ? ts_r - rd_row.start_time : '0;
    end
    if (cmd.calc) begin
      new_row_r <= new_row_nxt;
      req_r     <= req_nxt;
      evt_new_r <= evt_new_nxt;
    end
    if (cmd.commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

>>> rtl/function_timing_stats_table_top.sv
// output: an event passes the read, calc and done states; out_tvalid rises after done
//   commits it, once the output register is free; no new event is taken before then,
//   set by the single-port-read stats table ram (read, elapsed, update, write back)
// reset: rst_n synchronous active low; a clearing pass zeroes every table row
//   with in_tready low; cfg writes are taken throughout
`timescale 1ns / 1ps
`include "function_timing_stats_table_top_defines.svh"

module function_timing_stats_table_top #(
  parameter int NUM_FUNCS = fts_pkg::NUM_FUNCS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // func_index[7:0], timestamp[71:8]
  input  logic [fts_pkg::IN_DATA_W-1:0]      in_tdata,
  // cmd[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // elapsed[63:0], shortest[127:64], longest[191:128], time_sum[255:192],
  // calls_done[287:256], deactivate_request[288], deactivations[320:289], zero pad
  output logic [fts_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  // sample_limit
  input  logic [fts_pkg::CNT_W-1:0]          cfg_data
);

  fts_pkg::fts_cmd_t  dp_cmd;
  fts_pkg::fts_stat_t dp_stat;

  fts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (dp_stat),
    .cmd        (dp_cmd)
  );

  fts_datapath #(
    .NUM_FUNCS (NUM_FUNCS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .in_cmd    (in_tuser),
    .in_func   (in_tdata[fts_pkg::FI_W-1:0]),
    .in_ts     (in_tdata[fts_pkg::IN_DATA_W-1:fts_pkg::FI_W]),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_data  (out_tdata)
  );

  `FTS_ASSERT_IMM(a_commit_free, dp_cmd.commit, (!out_tvalid || out_tready), "beat overwritten")
  `FTS_ASSERT_NXT(a_one_item, (in_tvalid && in_tready), !in_tready, "second event taken")
  `FTS_ASSERT_IMM(a_clear_blocks, dp_cmd.clear_step, (!in_tready && !dp_cmd.commit), "in clear")

endmodule

>>> dv/fts_stats_checker.sv
// watches the event, result and limit channels of the timing stats table
// keeps its own copy of the per-function table and checks every result beat
// depends on fts_pkg for widths and the event kind enum
`timescale 1ns / 1ps

module fts_stats_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [fts_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [fts_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [fts_pkg::CNT_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            pending,
  output int                            events_seen,
  output int                            exits_seen,
  output int                            deacts_seen
);

  localparam int TABLE_DEPTH = fts_pkg::NUM_FUNCS_DEF;
  localparam int TS_W        = fts_pkg::TS_W;
  localparam int CNT_W       = fts_pkg::CNT_W;
  localparam int FI_W        = fts_pkg::FI_W;

  // result beat, lowest field last
  typedef struct packed {
    logic [fts_pkg::OUT_DATA_W-322:0] pad;
    logic [CNT_W-1:0]        deactivations;
    logic                    deact_req;
    logic [CNT_W-1:0]        calls_done;
    logic [TS_W-1:0]         time_sum;
    logic [TS_W-1:0]         longest;
    logic [TS_W-1:0]         shortest;
    logic [TS_W-1:0]         elapsed;
  } func_stats_t;

  logic [TS_W-1:0]  start_at  [TABLE_DEPTH];
  logic [TS_W-1:0]  min_dur   [TABLE_DEPTH];
  logic [TS_W-1:0]  max_dur   [TABLE_DEPTH];
  logic [TS_W-1:0]  sum_dur   [TABLE_DEPTH];
  logic [CNT_W-1:0] call_cnt  [TABLE_DEPTH];
  logic [CNT_W-1:0] deact_cnt [TABLE_DEPTH];
  logic [TS_W-1:0]  event_cnt;
  logic [CNT_W-1:0] deact_all;
  logic [CNT_W-1:0] pair_limit;

  func_stats_t stats_due[$];

  function automatic logic [CNT_W-1:0] bump32(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic func_stats_t predict_event(input fts_pkg::ev_kind_t kind,
                                                input logic [FI_W-1:0] fi,
                                                input logic [TS_W-1:0] ts);
    func_stats_t r;
    logic [TS_W-1:0] dur;
    r = '0;
    dur = '0;
    // index past the table: nothing moves, all-zero result
    if (int'(fi) >= TABLE_DEPTH) return r;
    if (event_cnt != '1) event_cnt = event_cnt + 1'b1;
    if (kind == fts_pkg::EV_ENTRY) begin
      start_at[fi] = ts;
    end else begin
      dur = ts - start_at[fi];
      call_cnt[fi] = bump32(call_cnt[fi]);
      // zero minimum means unset
      if (dur < min_dur[fi] || min_dur[fi] == '0) min_dur[fi] = dur;
      if (dur > max_dur[fi]) max_dur[fi] = dur;
      sum_dur[fi] = sum_dur[fi] + dur;
      if ((event_cnt >> 1) >= {32'd0, pair_limit}) begin
        r.deact_req = 1'b1;
        deact_all = bump32(deact_all);
        deact_cnt[fi] = bump32(deact_cnt[fi]);
      end
    end
    r.elapsed       = dur;
    r.shortest      = min_dur[fi];
    r.longest       = max_dur[fi];
    r.time_sum      = sum_dur[fi];
    r.calls_done    = call_cnt[fi];
    r.deactivations = deact_cnt[fi];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [TS_W-1:0] got,
                               input logic [TS_W-1:0] want);
    mismatches++;
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    func_stats_t got;
    func_stats_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        start_at[i]  = '0;
        min_dur[i]   = '0;
        max_dur[i]   = '0;
        sum_dur[i]   = '0;
        call_cnt[i]  = '0;
        deact_cnt[i] = '0;
      end
      event_cnt   = '0;
      deact_all   = '0;
      pair_limit  = fts_pkg::SAMPLE_LIMIT_RST;
      stats_due.delete();
      mismatches  = 0;
      events_seen = 0;
      exits_seen  = 0;
      deacts_seen = 0;
      pending    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) pair_limit = cfg_data;
      if (in_tvalid && in_tready) begin
        want = predict_event(fts_pkg::ev_kind_t'(in_tuser), in_tdata[FI_W-1:0],
                             in_tdata[FI_W +: TS_W]);
        stats_due.push_back(want);
        events_seen++;
        if (in_tuser == fts_pkg::EV_EXIT) exits_seen++;
        if (want.deact_req) deacts_seen++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (stats_due.size() == 0) begin
          flag_mismatch("result beat with nothing expected", got.elapsed, '0);
        end else begin
          want = stats_due.pop_front();
          if (got.elapsed != want.elapsed)
            flag_mismatch("elapsed", got.elapsed, want.elapsed);
          if (got.shortest != want.shortest)
            flag_mismatch("shortest", got.shortest, want.shortest);
          if (got.longest != want.longest)
            flag_mismatch("longest", got.longest, want.longest);
          if (got.time_sum != want.time_sum)
            flag_mismatch("time_sum", got.time_sum, want.time_sum);
          if (got.calls_done != want.calls_done)
            flag_mismatch("calls_done", 64'(got.calls_done), 64'(want.calls_done));
          if (got.deact_req != want.deact_req)
            flag_mismatch("deactivate_request", 64'(got.deact_req), 64'(want.deact_req));
          if (got.deactivations != want.deactivations)
            flag_mismatch("deactivations", 64'(got.deactivations),
                          64'(want.deactivations));
          if (got.pad != want.pad)
            flag_mismatch("padding bits", 64'(got.pad), 64'(want.pad));
        end
      end
      pending <= stats_due.size();
    end
  end

endmodule

>>> dv/tb_function_timing_stats_table_top.sv
// top of the timing stats table bench: clock, reset, event and limit stimulus
// depends on fts_pkg, function_timing_stats_table_top and fts_stats_checker
`timescale 1ns / 1ps

module tb_function_timing_stats_table_top;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int LATENCY_CYCLES = 3;
  localparam int HOLD_CYCLES    = 300;
  localparam int FI_W           = fts_pkg::FI_W;
  localparam int CNT_W          = fts_pkg::CNT_W;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [fts_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           in_tuser   = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [fts_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [CNT_W-1:0]               cfg_data   = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int cycles         = 0;

  // calls the stimulus has opened but not closed yet
  bit          open_call [fts_pkg::NUM_FUNCS_DEF];
  logic [63:0] open_ts   [fts_pkg::NUM_FUNCS_DEF];

  int mismatches, pending, events_seen, exits_seen, deacts_seen;

  function_timing_stats_table_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  fts_stats_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .pending     (pending),
    .events_seen (events_seen),
    .exits_seen  (exits_seen),
    .deacts_seen (deacts_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stall, or a long hold-off when asked
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one event beat; tvalid stays high across back-to-back beats
  task automatic send_event(input fts_pkg::ev_kind_t kind, input logic [FI_W-1:0] fi,
                            input logic [63:0] ts);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {ts, fi};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY_CYCLES + 4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly entry/exit pairs with random durations, some stray events
  task automatic run_phase(input int count);
    logic [FI_W-1:0]   fi;
    logic [63:0]       ts;
    logic [63:0]       dur;
    fts_pkg::ev_kind_t kind;
    int                r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 45)      fi = 8'($urandom_range(7));
      else if (r < 65) fi = 8'($urandom_range(255, 248));
      else             fi = 8'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 15)      dur = '0;
      else if (r < 60) dur = 64'($urandom_range(1000));
      else if (r < 85) dur = 64'($urandom);
      else             dur = rand64();
      if ($urandom_range(99) < 10) begin
        kind = fts_pkg::ev_kind_t'($urandom_range(1));
        ts   = rand64();
      end else if (open_call[fi]) begin
        kind = fts_pkg::EV_EXIT;
        ts   = open_ts[fi] + dur;
      end else begin
        kind = fts_pkg::EV_ENTRY;
        ts   = ($urandom_range(1)) ? rand64() : 64'($urandom_range(100000));
      end
      open_call[fi] = (kind == fts_pkg::EV_ENTRY);
      open_ts[fi]   = ts;
      send_event(kind, fi, ts);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed events at the reset limit
    send_event(fts_pkg::EV_ENTRY, 8'd0, 64'd0);
    send_event(fts_pkg::EV_EXIT, 8'd0, 64'd0);     // zero duration, minimum stays unset
    send_event(fts_pkg::EV_EXIT, 8'd3, 64'd100);   // exit with no entry
    send_event(fts_pkg::EV_ENTRY, 8'd255, '1);
    send_event(fts_pkg::EV_EXIT, 8'd255, 64'd5);   // duration wraps past 2^64
    send_event(fts_pkg::EV_ENTRY, 8'd255, 64'd10);
    send_event(fts_pkg::EV_EXIT, 8'd255, 64'd1010); // new longest
    send_event(fts_pkg::EV_ENTRY, 8'd255, 64'd20);
    send_event(fts_pkg::EV_EXIT, 8'd255, 64'd22);  // new shortest
    send_event(fts_pkg::EV_ENTRY, 8'd0, 64'd50);
    send_event(fts_pkg::EV_EXIT, 8'd0, 64'd53);    // first minimum
    send_event(fts_pkg::EV_ENTRY, 8'd0, 64'd60);
    send_event(fts_pkg::EV_EXIT, 8'd0, 64'd60);    // zero after a minimum is set
    send_event(fts_pkg::EV_ENTRY, 8'd128, 64'h8000_0000_0000_0000);
    send_event(fts_pkg::EV_EXIT, 8'd128, '1);
    send_event(fts_pkg::EV_EXIT, 8'd128, 64'd0);   // repeated exit on stale start
    send_event(fts_pkg::EV_ENTRY, 8'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_event(fts_pkg::EV_EXIT, 8'd1, 64'h5555_5555_5555_5555);
    drain();

    // limit of zero: every exit asks to deactivate
    set_limit('0);
    run_phase(300);
    drain();

    send_idle_pct = 81;
    set_limit('1);
    run_phase(300);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 81;
    set_limit(32'd1);
    run_phase(150);
    hold_req = 1'b1;
    run_phase(150);
    drain();

    send_idle_pct  = 20;
    recv_stall_pct = 20;
    set_limit(32'd1000);
    run_phase(400);
    drain();

    // limit crossed partway through this phase
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_limit(32'd700);
    run_phase(200);
    hold_req = 1'b1;
    run_phase(100);
    drain();
    run_phase(100);
    drain();

    $display("covered %0d events, %0d exits, %0d deactivation requests",
             events_seen, exits_seen, deacts_seen);
    $display("limits 1000, 0, max, 1, 1000, 700; mixed idling and two long output hold-offs");
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
